/* sv/easter_date_calculator_top_macros.svh */
// assertion macros for the easter date calculator
`ifndef EASTER_DATE_CALCULATOR_TOP_MACROS_SVH
`define EASTER_DATE_CALCULATOR_TOP_MACROS_SVH

`ifndef SYNTH
`define EDC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edc check failed");
`define EDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edc check failed");
`else
`define EDC_ASSERT_SAME(label, ante, cons)
`define EDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/edc_pkg.sv */
package edc_pkg;

	localparam int YearW      = 13;
	localparam int YearMax    = 5000;
	localparam int NumStages  = 12;

	// reciprocal constants for division by small constants
	localparam int Recip100   = 5243;	// >> 19
	localparam int Recip19    = 6899;	// >> 17
	localparam int Recip25    = 41;		// >> 10
	localparam int Recip3     = 171;	// >> 9
	localparam int Recip30    = 547;	// >> 14
	localparam int Recip7     = 147;	// >> 10

	localparam int LimitL     = 451;
	localparam int OffsetT    = 114;
	localparam int AprilStart = 124;	// 4 * 31
	localparam int LentOffset = 46;

	localparam logic [2:0] MonthMar = 3'd3;
	localparam logic [2:0] MonthApr = 3'd4;
	localparam logic [1:0] AshFeb   = 2'd2;
	localparam logic [1:0] AshMar   = 2'd3;

	typedef struct packed {
		logic ok;
		logic leap;
	} edc_flags_t;

	typedef struct packed {
		logic       year_valid;
		logic       leap_year;
		logic [2:0] easter_month;
		logic [4:0] easter_day;
		logic [2:0] friday_month;
		logic [4:0] friday_day;
		logic [1:0] ash_month;
		logic [4:0] ash_day;
	} edc_result_t;

endpackage

/* sv/edc_year_if.sv */
interface edc_year_if import edc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [YearW-1:0] calendar_year;

	modport source (output valid, output calendar_year, input ready);
	modport sink (input valid, input calendar_year, output ready);
endinterface

/* sv/edc_date_if.sv */
interface edc_date_if;
	logic       valid;
	logic       ready;
	logic       year_valid;
	logic       leap_year;
	logic [2:0] easter_month;
	logic [4:0] easter_day;
	logic [2:0] friday_month;
	logic [4:0] friday_day;
	logic [1:0] ash_month;
	logic [4:0] ash_day;

	modport source (
		output valid, output year_valid, output leap_year,
		output easter_month, output easter_day,
		output friday_month, output friday_day,
		output ash_month, output ash_day,
		input ready
	);
	modport sink (
		input valid, input year_valid, input leap_year,
		input easter_month, input easter_day,
		input friday_month, input friday_day,
		input ash_month, input ash_day,
		output ready
	);
endinterface

/* sv/easter_date_calculator_top.sv */
// an accepted year beat moves through stage 1 to stage 12 and leaves as its date beat
// throughput: one year per cycle while dates.ready is not held low; each of the 12 stages holds one item
// a stage loads whenever it is empty or the stage after it moves, so bubbles close up
// reset clears the stage valid bits only; the datapath registers are not reset
module easter_date_calculator_top import edc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	edc_year_if.sink   years,
	edc_date_if.source dates
);

	`include "easter_date_calculator_top_macros.svh"

	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] en;
	edc_result_t          result;

	// ready ripples back from the output register
	always_comb begin
		en[NumStages-1] = !vld_q[NumStages-1] || dates.ready;
		for (int k = NumStages - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= years.valid;
			end
			for (int k = 1; k < NumStages; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	edc_datapath u_datapath (
		.clk           (clk),
		.en            (en),
		.calendar_year (years.calendar_year),
		.result        (result)
	);

	assign years.ready        = en[0];
	assign dates.valid        = vld_q[NumStages-1];
	assign dates.year_valid   = result.year_valid;
	assign dates.leap_year    = result.leap_year;
	assign dates.easter_month = result.easter_month;
	assign dates.easter_day   = result.easter_day;
	assign dates.friday_month = result.friday_month;
	assign dates.friday_day   = result.friday_day;
	assign dates.ash_month    = result.ash_month;
	assign dates.ash_day      = result.ash_day;

	`EDC_ASSERT_NEXT(a_accept_enters, years.valid && years.ready, vld_q[0])
	`EDC_ASSERT_SAME(a_invalid_zero, dates.valid && !dates.year_valid, dates.easter_month == 3'd0 && dates.easter_day == 5'd0 && dates.friday_month == 3'd0 && dates.ash_month == 2'd0 && dates.ash_day == 5'd0)
	`EDC_ASSERT_SAME(a_easter_range, dates.valid && dates.year_valid, (dates.easter_month == MonthMar && dates.easter_day >= 5'd22) || (dates.easter_month == MonthApr && dates.easter_day <= 5'd25))
	`EDC_ASSERT_SAME(a_ash_month, dates.valid && dates.year_valid, dates.ash_month == AshFeb || dates.ash_month == AshMar)

endmodule

/* sv/edc_datapath.sv */
module edc_datapath import edc_pkg::*; (
	input  logic                 clk,
	input  logic [NumStages-1:0] en,
	input  logic [YearW-1:0]     calendar_year,
	output edc_result_t          result
);

	// stage 1: raw year
	logic [YearW-1:0] year_s1;

	// stage 2: a, b, c and flags
	logic [4:0] a_s2;
	logic [6:0] b_s2, c_s2;
	edc_flags_t fl_s2;

	// stage 3
	logic [4:0] a_s3, d_s3, i_s3;
	logic [6:0] b_s3;
	logic [1:0] e_s3, j_s3, f_s3;
	edc_flags_t fl_s3;

	// stage 4
	logic [4:0] a_s4, d_s4, i_s4, g_s4;
	logic [6:0] b_s4;
	logic [1:0] e_s4, j_s4;
	edc_flags_t fl_s4;

	// stage 5
	logic [8:0] hs_s5;
	logic [4:0] a_s5, i_s5;
	logic [1:0] e_s5, j_s5;
	edc_flags_t fl_s5;

	// stage 6
	logic [4:0] h_s6, a_s6, i_s6;
	logic [1:0] e_s6, j_s6;
	edc_flags_t fl_s6;

	// stage 7
	logic [6:0] ks_s7;
	logic [4:0] h_s7, a_s7;
	edc_flags_t fl_s7;

	// stage 8
	logic [2:0] k_s8;
	logic [4:0] h_s8, a_s8;
	edc_flags_t fl_s8;

	// stage 9
	logic [8:0] lsum_s9;
	logic [4:0] h_s9;
	logic [2:0] k_s9;
	edc_flags_t fl_s9;

	// stage 10
	logic [7:0] t_s10;
	edc_flags_t fl_s10;

	// stage 11
	logic       apr_s11;
	logic [4:0] ed_s11;
	edc_flags_t fl_s11;

	// stage 12: output register
	edc_result_t res_s12;

	// comb signals
	logic [25:0] prod100_c, prod19_c;
	logic [6:0]  b_c, c_c;
	logic [8:0]  q19_c;
	logic [12:0] rem19_c, rem100_c;
	logic        ok_c, leap_c;
	logic [11:0] prod25_c;
	logic [1:0]  f_c;
	logic [6:0]  gx_c;
	logic [13:0] prod3_c;
	logic [8:0]  hs_c;
	logic [18:0] prod30_c;
	logic [8:0]  rem30_c;
	logic [6:0]  ks_c;
	logic [13:0] prod7_c;
	logic [6:0]  rem7_c;
	logic [8:0]  lsum_c;
	logic [7:0]  t_c;
	logic        apr_c;
	logic [4:0]  ed_c;
	logic [5:0]  x_c;
	edc_result_t res_c;

	// year / 100 and year / 19 by reciprocal multiply
	always_comb begin
		prod100_c = 26'(year_s1) * 26'(Recip100);
		prod19_c  = 26'(year_s1) * 26'(Recip19);
		b_c       = prod100_c[25:19];
		q19_c     = prod19_c[25:17];
		rem19_c   = year_s1 - 13'(13'(q19_c) * 13'd19);
		rem100_c  = year_s1 - 13'(13'(b_c) * 13'd100);
		c_c       = rem100_c[6:0];
		ok_c      = (year_s1 != '0) && (year_s1 <= YearW'(YearMax));
		// century years are leap only when divisible by 400
		leap_c    = (c_c == '0) ? (b_c[1:0] == 2'd0) : (year_s1[1:0] == 2'd0);
	end

	always_comb begin
		prod25_c = 12'(b_s2 + 7'd8) * 12'(Recip25);
		f_c      = prod25_c[11:10];
	end

	always_comb begin
		gx_c    = b_s3 - 7'(f_s3) + 7'd1;
		prod3_c = 14'(gx_c) * 14'(Recip3);
	end

	always_comb begin
		hs_c = 9'(9'(a_s4) * 9'd19) + 9'(b_s4) - 9'(d_s4) - 9'(g_s4) + 9'd15;
	end

	always_comb begin
		prod30_c = 19'(hs_s5) * 19'(Recip30);
		rem30_c  = hs_s5 - 9'(9'(prod30_c[18:14]) * 9'd30);
	end

	always_comb begin
		ks_c = 7'd32 + 7'({e_s6, 1'b0}) + 7'({i_s6, 1'b0}) - 7'(h_s6) - 7'(j_s6);
	end

	always_comb begin
		prod7_c = 14'(ks_s7) * 14'(Recip7);
		rem7_c  = ks_s7 - 7'(7'(prod7_c[13:10]) * 7'd7);
	end

	always_comb begin
		lsum_c = 9'(a_s8) + 9'(9'(h_s8) * 9'd11) + 9'(9'(k_s8) * 9'd22);
	end

	// the quotient by 451 is only ever 0 or 1
	always_comb begin
		t_c = 8'(h_s9) + 8'(k_s9) + 8'(OffsetT);
		if (lsum_s9 >= 9'(LimitL)) begin
			t_c = t_c - 8'd7;
		end
	end

	// t lies in 107..149, so the month is 3 or 4
	always_comb begin
		apr_c = t_s10 >= 8'(AprilStart);
		ed_c  = apr_c ? 5'(t_s10 - 8'(AprilStart - 1)) : 5'(t_s10 - 8'(AprilStart - 32));
	end

	always_comb begin
		res_c = '0;
		res_c.leap_year = fl_s11.leap;
		if (fl_s11.ok) begin
			res_c.year_valid   = 1'b1;
			res_c.easter_month = apr_s11 ? MonthApr : MonthMar;
			res_c.easter_day   = ed_s11;
			// good friday wraps into march on the first two days of april
			if (ed_s11 == 5'd2) begin
				res_c.friday_month = MonthMar;
				res_c.friday_day   = 5'd31;
			end else if (ed_s11 == 5'd1) begin
				res_c.friday_month = MonthMar;
				res_c.friday_day   = 5'd30;
			end else begin
				res_c.friday_month = res_c.easter_month;
				res_c.friday_day   = ed_s11 - 5'd2;
			end
			// x counts days past the end of february
			x_c = 6'(ed_s11) + (apr_s11 ? 6'd31 : 6'd0);
			if (x_c <= 6'(LentOffset)) begin
				res_c.ash_month = AshFeb;
				res_c.ash_day   = 5'(x_c - 6'd18 + 6'(fl_s11.leap));
			end else begin
				res_c.ash_month = AshMar;
				res_c.ash_day   = 5'(x_c - 6'(LentOffset));
			end
		end else begin
			x_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			year_s1 <= calendar_year;
		end
		if (en[1]) begin
			a_s2  <= rem19_c[4:0];
			b_s2  <= b_c;
			c_s2  <= c_c;
			fl_s2 <= '{ok: ok_c, leap: leap_c};
		end
		if (en[2]) begin
			a_s3  <= a_s2;
			b_s3  <= b_s2;
			d_s3  <= b_s2[6:2];
			e_s3  <= b_s2[1:0];
			i_s3  <= c_s2[6:2];
			j_s3  <= c_s2[1:0];
			f_s3  <= f_c;
			fl_s3 <= fl_s2;
		end
		if (en[3]) begin
			a_s4  <= a_s3;
			b_s4  <= b_s3;
			d_s4  <= d_s3;
			e_s4  <= e_s3;
			i_s4  <= i_s3;
			j_s4  <= j_s3;
			g_s4  <= prod3_c[13:9];
			fl_s4 <= fl_s3;
		end
		if (en[4]) begin
			hs_s5 <= hs_c;
			a_s5  <= a_s4;
			e_s5  <= e_s4;
			i_s5  <= i_s4;
			j_s5  <= j_s4;
			fl_s5 <= fl_s4;
		end
		if (en[5]) begin
			h_s6  <= rem30_c[4:0];
			a_s6  <= a_s5;
			e_s6  <= e_s5;
			i_s6  <= i_s5;
			j_s6  <= j_s5;
			fl_s6 <= fl_s5;
		end
		if (en[6]) begin
			ks_s7 <= ks_c;
			h_s7  <= h_s6;
			a_s7  <= a_s6;
			fl_s7 <= fl_s6;
		end
		if (en[7]) begin
			k_s8  <= rem7_c[2:0];
			h_s8  <= h_s7;
			a_s8  <= a_s7;
			fl_s8 <= fl_s7;
		end
		if (en[8]) begin
			lsum_s9 <= lsum_c;
			h_s9    <= h_s8;
			k_s9    <= k_s8;
			fl_s9   <= fl_s8;
		end
		if (en[9]) begin
			t_s10  <= t_c;
			fl_s10 <= fl_s9;
		end
		if (en[10]) begin
			apr_s11 <= apr_c;
			ed_s11  <= ed_c;
			fl_s11  <= fl_s10;
		end
		if (en[11]) begin
			res_s12 <= res_c;
		end
	end

	assign result = res_s12;

endmodule
